// ===== hw/rtl/stack_machine_execute_assert.svh =====
`ifndef STACK_MACHINE_EXECUTE_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_ASSERT_SVH
// assertion helpers, clocked on clk and disabled in reset
`define SME_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SME_ASSERT_NEXT(label, cond, nxt, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error(msg);
`endif

// ===== hw/rtl/sme_pkg.sv =====
package sme_pkg;
    localparam logic [4:0] OP_LOAD  = 5'd0;
    localparam logic [4:0] OP_LOADI = 5'd1;
    localparam logic [4:0] OP_STO   = 5'd2;
    localparam logic [4:0] OP_POP   = 5'd3;
    localparam logic [4:0] OP_ADD   = 5'd4;
    localparam logic [4:0] OP_SUB   = 5'd5;
    localparam logic [4:0] OP_MULT  = 5'd6;
    localparam logic [4:0] OP_DIV   = 5'd7;
    localparam logic [4:0] OP_BR    = 5'd8;
    localparam logic [4:0] OP_BRF   = 5'd9;
    localparam logic [4:0] OP_EQ    = 5'd10;
    localparam logic [4:0] OP_NOTEQ = 5'd11;
    localparam logic [4:0] OP_GT    = 5'd12;
    localparam logic [4:0] OP_LES   = 5'd13;
    localparam logic [4:0] OP_GE    = 5'd14;
    localparam logic [4:0] OP_LE    = 5'd15;
    localparam logic [4:0] OP_AND   = 5'd16;
    localparam logic [4:0] OP_OR    = 5'd17;
    localparam logic [4:0] OP_NOT   = 5'd18;
    localparam logic [4:0] OP_IN    = 5'd19;
    localparam logic [4:0] OP_OUT   = 5'd20;
    localparam logic [4:0] OP_STOP  = 5'd21;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_HALTED = 3'd1;
    localparam logic [2:0] ST_BADOP  = 3'd2;
    localparam logic [2:0] ST_STACK  = 3'd3;
    localparam logic [2:0] ST_DIVZ   = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic clear_step;    // write one zero into data memory during clear
        logic capture;       // register input word
        logic read_ops;      // issue stack/memory reads
        logic mul_step;      // register product
        logic div_start;
        logic commit;        // apply effects and load result
    } sme_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic is_mul;
        logic is_div;
        logic div_busy;
    } sme_stat_t;
endpackage

// ===== hw/rtl/sme_ram.sv =====
module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/sme_div.sv =====
// restoring divider on magnitudes, one quotient bit per cycle
module sme_div #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic         busy,
    output logic [W-1:0] q
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  den_reg, den_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [W:0]    trial;

    assign trial = {rem_reg, quo_reg[W-1]} - {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = a[W-1] ? -a : a;
            den_next  = b[W-1] ? -b : b;
            neg_next  = a[W-1] ^ b[W-1];
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[W])
            begin
                rem_next = {rem_reg[W-2:0], quo_reg[W-1]};
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign busy = busy_reg;
    assign q    = neg_reg ? -quo_reg : quo_reg;
endmodule

// ===== hw/rtl/sme_datapath.sv =====
module sme_datapath #(
    parameter int STACK_DEPTH   = 1024,
    parameter int DATA_WORDS    = 1024,
    parameter int PROGRAM_WORDS = 1024,
    parameter int WORD_BITS     = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sme_pkg::sme_cmd_t    cmd_bus,
    output sme_pkg::sme_stat_t   stat_bus,
    input  logic                 cfg_valid,
    input  logic [10:0]          cfg_data,
    input  logic [4:0]           cmd,
    input  logic [31:0]          immediate,
    input  logic [9:0]           address,
    input  logic [31:0]          in_value,
    output logic [2:0]           status,
    output logic                 out_valid,
    output logic [31:0]          out_value,
    output logic [10:0]          next_pc
);
    import sme_pkg::*;

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int STW = $clog2(STACK_DEPTH + 1);
    localparam int DAW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
    localparam int W   = WORD_BITS;
    localparam logic [10:0] PLIM = (PROGRAM_WORDS > 1024) ? 11'd1024 : 11'(PROGRAM_WORDS);

    logic [10:0]    plen_reg;
    logic [STW-1:0] sp_reg, sp_next;
    logic [10:0]    pc_reg, pc_next;
    logic           halt_reg, halt_next;
    logic [DAW-1:0] clr_reg;
    logic           clr_done_reg;

    logic [4:0]  op_reg;
    logic [31:0] imm_reg, inv_reg;
    logic [9:0]  adr_reg;

    logic [W-1:0] a_reg, b_reg;          // second and top of stack
    logic [W-1:0] prod_reg;

    logic [W-1:0]   top_rd, sec_rd, mem_rd;
    logic [SAW-1:0] top_ra, sec_ra;
    logic           swe;
    logic [SAW-1:0] swa;
    logic [W-1:0]   swd;
    logic           dwe;
    logic [DAW-1:0] dwa;
    logic [W-1:0]   dwd;
    logic           div_busy;
    logic [W-1:0]   div_q;
    logic           adr_ok;

    logic [2:0]  st_reg, st_next;
    logic        ov_reg, ov_next;
    logic [31:0] oval_reg, oval_next;

    assign adr_ok = ({22'd0, adr_reg} < 32'(DATA_WORDS));

    // two read ports: keep two copies of the stack written alike
    assign top_ra = SAW'(sp_reg - 1'b1);
    assign sec_ra = SAW'(sp_reg - 2'd2);

    sme_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_stk_a (
        .clk(clk), .we(swe), .waddr(swa), .wdata(swd), .raddr(top_ra), .rdata(top_rd));
    sme_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_stk_b (
        .clk(clk), .we(swe), .waddr(swa), .wdata(swd), .raddr(sec_ra), .rdata(sec_rd));
    sme_ram #(.WIDTH(W), .DEPTH(DATA_WORDS)) u_dmem (
        .clk(clk), .we(dwe), .waddr(dwa), .wdata(dwd), .raddr(DAW'(adr_reg)),
        .rdata(mem_rd));

    sme_div #(.W(W)) u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd_bus.div_start), .a(a_reg), .b(b_reg),
        .busy(div_busy), .q(div_q));

    assign stat_bus.clear_done = clr_done_reg;
    assign stat_bus.is_mul     = (op_reg == OP_MULT);
    assign stat_bus.is_div     = (op_reg == OP_DIV);
    assign stat_bus.div_busy   = div_busy;

    // execute the captured instruction
    logic [1:0]   need;
    logic         push;
    logic         lt_ab, lt_ba;
    logic [W-1:0] r;
    logic [W-1:0] pushv;

    assign lt_ab = $signed(a_reg) < $signed(b_reg);
    assign lt_ba = $signed(b_reg) < $signed(a_reg);

    always_comb
    begin
        push = (op_reg == OP_LOAD) || (op_reg == OP_LOADI) || (op_reg == OP_IN);
        need = 2'd0;
        if (op_reg == OP_STO || op_reg == OP_POP || op_reg == OP_BRF ||
            op_reg == OP_NOT || op_reg == OP_OUT)
        begin
            need = 2'd1;
        end
        else if ((op_reg >= OP_ADD && op_reg <= OP_DIV) ||
                 (op_reg >= OP_EQ && op_reg <= OP_OR))
        begin
            need = 2'd2;
        end
        unique case (op_reg)
            OP_ADD:   r = a_reg + b_reg;
            OP_SUB:   r = a_reg - b_reg;
            OP_MULT:  r = prod_reg;
            OP_DIV:   r = div_q;
            OP_EQ:    r = W'(a_reg == b_reg);
            OP_NOTEQ: r = W'(a_reg != b_reg);
            OP_GT:    r = W'(lt_ba);
            OP_LES:   r = W'(lt_ab);
            OP_GE:    r = W'(!lt_ab);
            OP_LE:    r = W'(!lt_ba);
            OP_AND:   r = W'((a_reg != '0) && (b_reg != '0));
            default:  r = W'((a_reg != '0) || (b_reg != '0));
        endcase
        unique case (op_reg)
            OP_LOAD:  pushv = adr_ok ? mem_rd : '0;
            OP_LOADI: pushv = W'($signed(imm_reg));
            default:  pushv = W'($signed(inv_reg));
        endcase
    end

    always_comb
    begin
        sp_next   = sp_reg;
        pc_next   = pc_reg;
        halt_next = halt_reg;
        st_next   = st_reg;
        ov_next   = ov_reg;
        oval_next = oval_reg;
        swe = 1'b0;
        swa = top_ra;
        swd = r;
        dwe = 1'b0;
        dwa = DAW'(adr_reg);
        dwd = b_reg;
        if (!clr_done_reg)
        begin
            dwe = cmd_bus.clear_step;
            dwa = clr_reg;
            dwd = '0;
        end
        if (cmd_bus.commit)
        begin
            st_next   = ST_OK;
            ov_next   = 1'b0;
            oval_next = '0;
            priority if (halt_reg || pc_reg >= plen_reg)
            begin
                halt_next = 1'b1;
                st_next   = ST_HALTED;
            end
            else if (op_reg > OP_STOP)
            begin
                halt_next = 1'b1;
                st_next   = ST_BADOP;
            end
            else if ((push && {1'b0, sp_reg} >= (STW+1)'(STACK_DEPTH)) ||
                     sp_reg < STW'(need))
            begin
                halt_next = 1'b1;
                st_next   = ST_STACK;
            end
            else if (op_reg == OP_DIV && b_reg == '0)
            begin
                halt_next = 1'b1;
                st_next   = ST_DIVZ;
            end
            else
            begin
                pc_next = pc_reg + 1'b1;
                if (need == 2'd2)
                begin
                    swe = 1'b1;
                    swa = sec_ra;
                    sp_next = sp_reg - 1'b1;
                end
                else if (push)
                begin
                    swe = 1'b1;
                    swa = SAW'(sp_reg);
                    swd = pushv;
                    sp_next = sp_reg + 1'b1;
                end
                else
                begin
                    unique case (op_reg)
                        OP_STO:
                        begin
                            dwe = adr_ok;
                        end
                        OP_POP:
                        begin
                            sp_next = sp_reg - 1'b1;
                        end
                        OP_BR:
                        begin
                            pc_next = {1'b0, adr_reg};
                        end
                        OP_BRF:
                        begin
                            sp_next = sp_reg - 1'b1;
                            if (b_reg == '0)
                            begin
                                pc_next = {1'b0, adr_reg};
                            end
                        end
                        OP_NOT:
                        begin
                            swe = 1'b1;
                            swd = W'(b_reg == '0);
                        end
                        OP_OUT:
                        begin
                            sp_next   = sp_reg - 1'b1;
                            ov_next   = 1'b1;
                            oval_next = 32'(b_reg);
                        end
                        default:
                        begin
                            halt_next = 1'b1;
                            st_next   = ST_HALTED;
                            pc_next   = pc_reg;
                        end
                    endcase
                end
                if (pc_next >= plen_reg)
                begin
                    halt_next = 1'b1;
                    st_next   = ST_HALTED;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg     <= '0;
            sp_reg       <= '0;
            pc_reg       <= '0;
            halt_reg     <= 1'b0;
            clr_reg      <= '0;
            clr_done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                plen_reg <= (cfg_data > PLIM) ? PLIM : cfg_data;
            end
            sp_reg   <= sp_next;
            pc_reg   <= pc_next;
            halt_reg <= halt_next;
            if (!clr_done_reg && cmd_bus.clear_step)
            begin
                clr_reg <= clr_reg + 1'b1;
                if ({1'b0, clr_reg} == (DAW+1)'(DATA_WORDS - 1))
                begin
                    clr_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_bus.capture)
        begin
            op_reg  <= cmd;
            imm_reg <= immediate;
            adr_reg <= address;
            inv_reg <= in_value;
        end
        if (cmd_bus.read_ops)
        begin
            a_reg <= sec_rd;
            b_reg <= top_rd;
        end
        if (cmd_bus.mul_step)
        begin
            prod_reg <= a_reg * b_reg;
        end
        st_reg   <= st_next;
        ov_reg   <= ov_next;
        oval_reg <= oval_next;
    end

    assign status    = st_reg;
    assign out_valid = ov_reg;
    assign out_value = oval_reg;
    assign next_pc   = pc_reg;
endmodule

// ===== hw/rtl/sme_ctrl.sv =====
`include "stack_machine_execute_assert.svh"
module sme_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               res_stall,
    output logic               res_valid,
    output sme_pkg::sme_cmd_t  cmd_bus,
    input  sme_pkg::sme_stat_t stat_bus
);
    import sme_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       acc;

    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign acc       = in_valid && !in_stall;

    always_comb
    begin
        state_next         = state_reg;
        cmd_bus.clear_step = (state_reg == S_CLEAR);
        cmd_bus.capture    = acc;
        cmd_bus.read_ops   = (state_reg == S_READ);
        cmd_bus.mul_step   = (state_reg == S_EXEC);
        cmd_bus.div_start  = 1'b0;
        cmd_bus.commit     = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat_bus.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (acc)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (stat_bus.is_div)
                begin
                    cmd_bus.div_start = 1'b1;
                    state_next = S_WAIT;
                end
                else if (stat_bus.is_mul)
                begin
                    state_next = S_WAIT;
                end
                else
                begin
                    cmd_bus.commit = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_WAIT:
            begin
                if (!stat_bus.div_busy)
                begin
                    cmd_bus.commit = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!res_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `SME_ASSERT_NEXT(a_acc_read, acc, state_reg == S_READ, "accepted word not read")
    `SME_ASSERT(a_one_commit, !(cmd_bus.commit && cmd_bus.capture), "commit during capture")
    `SME_ASSERT_NEXT(a_commit_done, cmd_bus.commit, res_valid, "commit without result")
endmodule

// ===== hw/rtl/stack_machine_execute.sv =====
// Executes one decoded stack-machine instruction per input word and returns one
// result word per instruction. After reset the data memory is swept to zero, one
// word a cycle, through all DATA_WORDS words; no instruction is taken during that
// sweep or in the cycle after it.
// An instruction then passes the read of the stack memories, execute and the result
// register; a multiply adds a registered product and a divide waits for the divider
// (one quotient bit a cycle). The block goes back to idle once the result is taken;
// one instruction is in flight.
module stack_machine_execute #(
    parameter int STACK_DEPTH   = 1024,
    parameter int DATA_WORDS    = 1024,
    parameter int PROGRAM_WORDS = 1024,
    parameter int WORD_BITS     = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [4:0]  cmd,
    input  logic [31:0] immediate,
    input  logic [9:0]  address,
    input  logic [31:0] in_value,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [2:0]  status,
    output logic        out_valid,
    output logic [31:0] out_value,
    output logic [10:0] next_pc,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data
);
    import sme_pkg::*;

    sme_cmd_t  cmd_bus;
    sme_stat_t stat_bus;

    assign cfg_ready = 1'b1;

    sme_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .res_stall(res_stall), .res_valid(res_valid), .cmd_bus(cmd_bus),
        .stat_bus(stat_bus));

    sme_datapath #(
        .STACK_DEPTH(STACK_DEPTH), .DATA_WORDS(DATA_WORDS),
        .PROGRAM_WORDS(PROGRAM_WORDS), .WORD_BITS(WORD_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd_bus(cmd_bus), .stat_bus(stat_bus),
        .cfg_valid(cfg_valid), .cfg_data(cfg_data), .cmd(cmd),
        .immediate(immediate), .address(address), .in_value(in_value),
        .status(status), .out_valid(out_valid), .out_value(out_value),
        .next_pc(next_pc));
endmodule

// ===== tb/sv/stack_machine_execute_tb.sv =====
module stack_machine_execute_tb;
    import sme_pkg::*;

    localparam int STACK_WORDS = 1024;
    localparam int PROG_MAX    = 1024;
    localparam int DOG_LIMIT   = 6000;

    typedef struct packed {
        logic [2:0]  status;
        logic        out_valid;
        logic [31:0] out_value;
        logic [10:0] next_pc;
    } exec_result_t;

    typedef struct {
        logic [4:0]  op;
        logic [31:0] imm;
        logic [9:0]  addr;
        logic [31:0] inv;
        bit          known;
        logic [2:0]  st;
        logic [10:0] npc;
    } instr_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [4:0]  cmd = '0;
    logic [31:0] immediate = '0;
    logic [9:0]  address = '0;
    logic [31:0] in_value = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [2:0]  status;
    logic        out_valid;
    logic [31:0] out_value;
    logic [10:0] next_pc;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [10:0] cfg_data = '0;

    // machine state as the predictor sees it
    logic [31:0] opnd_stack [STACK_WORDS];
    logic [31:0] data_mem [1024];
    int          stack_ptr;
    int          prog_ctr;
    int          prog_len;
    bit          is_halted;

    exec_result_t pending_results[$];
    int          mismatches;
    int          stall_left;
    int          dog_count;
    bit          idle_on;

    stack_machine_execute u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .immediate (immediate),
        .address   (address),
        .in_value  (in_value),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .status    (status),
        .out_valid (out_valid),
        .out_value (out_value),
        .next_pc   (next_pc),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        if (mismatches < 40)
            $display("mismatch on %s: got %0h expected %0h", field, got, want);
        mismatches++;
    endtask

    function automatic exec_result_t execute_word(logic [4:0] op, logic [31:0] imm,
                                                  logic [9:0] addr, logic [31:0] inv);
        exec_result_t r;
        int           need;
        bit           pushes;
        int           npc;
        logic [31:0]  a;
        logic [31:0]  b;
        logic [31:0]  v;
        logic [31:0]  ma;
        logic [31:0]  mb;
        logic [31:0]  q;
        r = '0;
        need = 0;
        pushes = 0;
        npc = prog_ctr + 1;
        if (is_halted || prog_ctr >= prog_len)
        begin
            is_halted = 1;
            r.status = ST_HALTED;
            r.next_pc = prog_ctr[10:0];
            return r;
        end
        if (op > OP_STOP)
        begin
            is_halted = 1;
            r.status = ST_BADOP;
            r.next_pc = prog_ctr[10:0];
            return r;
        end
        if (op == OP_LOAD || op == OP_LOADI || op == OP_IN)
            pushes = 1;
        else if (op == OP_STO || op == OP_POP || op == OP_BRF || op == OP_NOT || op == OP_OUT)
            need = 1;
        else if ((op >= OP_ADD && op <= OP_DIV) || (op >= OP_EQ && op <= OP_OR))
            need = 2;
        if ((pushes && stack_ptr >= STACK_WORDS) || stack_ptr < need)
        begin
            is_halted = 1;
            r.status = ST_STACK;
            r.next_pc = prog_ctr[10:0];
            return r;
        end
        if (op == OP_DIV && opnd_stack[stack_ptr - 1] == 0)
        begin
            is_halted = 1;
            r.status = ST_DIVZ;
            r.next_pc = prog_ctr[10:0];
            return r;
        end
        if (need == 2)
        begin
            a = opnd_stack[stack_ptr - 2];
            b = opnd_stack[stack_ptr - 1];
            case (op)
                OP_ADD:   v = a + b;
                OP_SUB:   v = a - b;
                OP_MULT:  v = a * b;
                OP_DIV:
                begin
                    ma = a[31] ? -a : a;
                    mb = b[31] ? -b : b;
                    q = ma / mb;
                    v = (a[31] ^ b[31]) ? -q : q;
                end
                OP_EQ:    v = {31'b0, a == b};
                OP_NOTEQ: v = {31'b0, a != b};
                OP_GT:    v = {31'b0, $signed(a) > $signed(b)};
                OP_LES:   v = {31'b0, $signed(a) < $signed(b)};
                OP_GE:    v = {31'b0, $signed(a) >= $signed(b)};
                OP_LE:    v = {31'b0, $signed(a) <= $signed(b)};
                OP_AND:   v = {31'b0, a != 0 && b != 0};
                default:  v = {31'b0, a != 0 || b != 0};
            endcase
            opnd_stack[stack_ptr - 2] = v;
            stack_ptr--;
        end
        else
        begin
            case (op)
                OP_LOAD:  opnd_stack[stack_ptr++] = data_mem[addr];
                OP_LOADI: opnd_stack[stack_ptr++] = imm;
                OP_STO:   data_mem[addr] = opnd_stack[stack_ptr - 1];
                OP_POP:   stack_ptr--;
                OP_BR:    npc = addr;
                OP_BRF:
                begin
                    stack_ptr--;
                    if (opnd_stack[stack_ptr] == 0)
                        npc = addr;
                end
                OP_NOT:   opnd_stack[stack_ptr - 1] = {31'b0, opnd_stack[stack_ptr - 1] == 0};
                OP_IN:    opnd_stack[stack_ptr++] = inv;
                OP_OUT:
                begin
                    stack_ptr--;
                    r.out_valid = 1'b1;
                    r.out_value = opnd_stack[stack_ptr];
                end
                default:
                begin
                    is_halted = 1;
                    r.status = ST_HALTED;
                    npc = prog_ctr;
                end
            endcase
        end
        prog_ctr = npc;
        if (prog_ctr >= prog_len)
        begin
            is_halted = 1;
            r.status = ST_HALTED;
        end
        r.next_pc = prog_ctr[10:0];
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hffff_ffff;
            3: return 32'h7fff_ffff;
            4: return 32'h8000_0000;
            5: return $urandom_range(0, 20);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [9:0] pick_addr();
        if ($urandom_range(0, 3) == 0)
            return 10'($urandom);
        return 10'($urandom_range(0, 15));
    endfunction

    task automatic send_instr(logic [4:0] op, logic [31:0] imm, logic [9:0] addr,
                              logic [31:0] inv, bit known = 0, exec_result_t typed = '0);
        exec_result_t p;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        immediate <= imm;
        address <= addr;
        in_value <= inv;
        do @(posedge clk); while (in_stall);
        p = execute_word(op, imm, addr, inv);
        pending_results = {pending_results, (known ? typed : p)};
    endtask

    // one step of a program that never faults; branches back before running off the end
    task automatic send_legal();
        logic [4:0] op;
        int         need;
        op = 5'($urandom_range(0, 20));
        if (prog_ctr + 1 >= prog_len)
            op = OP_BR;
        else
        begin
            need = 0;
            if (op == OP_STO || op == OP_POP || op == OP_BRF || op == OP_NOT || op == OP_OUT)
                need = 1;
            else if ((op >= OP_ADD && op <= OP_DIV) || (op >= OP_EQ && op <= OP_OR))
                need = 2;
            if (stack_ptr < need)
                op = ($urandom_range(0, 1) == 0) ? OP_LOADI : OP_IN;
            if ((op == OP_LOAD || op == OP_LOADI || op == OP_IN) && stack_ptr >= 48)
                op = OP_POP;
            if (op == OP_DIV && opnd_stack[stack_ptr - 1] == 0)
                op = OP_SUB;
        end
        send_instr(op, pick_value(), (op == OP_BR || op == OP_BRF) ?
                   10'($urandom_range(0, prog_len - 1)) : pick_addr(), pick_value());
    endtask

    // issue op, first branching back if the program end is next
    task automatic send_guarded(logic [4:0] op, logic [31:0] imm);
        if (prog_ctr + 1 >= prog_len)
            send_instr(OP_BR, $urandom, 10'($urandom_range(0, prog_len - 1)), $urandom);
        send_instr(op, imm, pick_addr(), $urandom);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_length(logic [10:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        prog_len = (v > PROG_MAX) ? PROG_MAX : v;
    endtask

    // result check, result-side stall and watchdog
    always @(posedge clk)
    begin
        exec_result_t e;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (pending_results.size() == 0)
                    report("unexpected word", {29'b0, status}, 32'b0);
                else
                begin
                    e = pending_results.pop_front();
                    if (status !== e.status)
                        report("status", {29'b0, status}, {29'b0, e.status});
                    if (out_valid !== e.out_valid)
                        report("out_valid", {31'b0, out_valid}, {31'b0, e.out_valid});
                    if (out_value !== e.out_value)
                        report("out_value", out_value, e.out_value);
                    if (next_pc !== e.next_pc)
                        report("next_pc", {21'b0, next_pc}, {21'b0, e.next_pc});
                end
            end
            if ((res_valid && !res_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
                dog_count <= 0;
            else if (dog_count >= DOG_LIMIT)
            begin
                $display("stack_machine_execute_tb: FAIL");
                $finish;
            end
            else
                dog_count <= dog_count + 1;
        end
        if (!idle_on)
        begin
            stall_left <= 0;
            res_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            if (stall_left == 1)
                res_stall <= 1'b0;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            res_stall <= 1'b1;
            stall_left <= $urandom_range(1, 9);
        end
        else
            res_stall <= 1'b0;
    end

    instr_row_t directed[] = '{
        '{OP_LOADI, 32'h7fff_ffff, 10'd0,    32'd0,         1, ST_OK, 11'd1},
        '{OP_LOADI, 32'h8000_0000, 10'd0,    32'd0,         1, ST_OK, 11'd2},
        '{OP_SUB,   32'd0,         10'd0,    32'd0,         0, ST_OK, 11'd0},
        '{OP_IN,    32'd0,         10'd0,    32'hffff_ffff, 0, ST_OK, 11'd0},
        '{OP_MULT,  32'd0,         10'd0,    32'd0,         0, ST_OK, 11'd0},
        '{OP_LOADI, 32'h8000_0000, 10'd0,    32'd0,         0, ST_OK, 11'd0},
        '{OP_IN,    32'd0,         10'd0,    32'hffff_ffff, 0, ST_OK, 11'd0},
        '{OP_DIV,   32'd0,         10'd0,    32'd0,         0, ST_OK, 11'd0},
        '{OP_STO,   32'd0,         10'd1023, 32'd0,         0, ST_OK, 11'd0},
        '{OP_LOAD,  32'd0,         10'd1023, 32'd0,         0, ST_OK, 11'd0},
        '{OP_EQ,    32'd0,         10'd0,    32'd0,         0, ST_OK, 11'd0},
        '{OP_LOAD,  32'd0,         10'd0,    32'd0,         0, ST_OK, 11'd0},
        '{OP_NOTEQ, 32'd0,         10'd0,    32'd0,         0, ST_OK, 11'd0},
        '{OP_GT,    32'd0,         10'd0,    32'd0,         0, ST_OK, 11'd0},
        '{OP_IN,    32'd0,         10'd0,    32'h7fff_ffff, 0, ST_OK, 11'd0},
        '{OP_LES,   32'd0,         10'd0,    32'd0,         0, ST_OK, 11'd0},
        '{OP_NOT,   32'd0,         10'd0,    32'd0,         0, ST_OK, 11'd0},
        '{OP_LOADI, 32'hffff_ffff, 10'd0,    32'd0,         0, ST_OK, 11'd0},
        '{OP_GE,    32'd0,         10'd0,    32'd0,         0, ST_OK, 11'd0},
        '{OP_LOADI, 32'd0,         10'd0,    32'd0,         0, ST_OK, 11'd0},
        '{OP_LE,    32'd0,         10'd0,    32'd0,         0, ST_OK, 11'd0},
        '{OP_LOADI, 32'd3,         10'd0,    32'd0,         0, ST_OK, 11'd0},
        '{OP_AND,   32'd0,         10'd0,    32'd0,         0, ST_OK, 11'd0},
        '{OP_LOADI, 32'd0,         10'd0,    32'd0,         0, ST_OK, 11'd0},
        '{OP_OR,    32'd0,         10'd0,    32'd0,         0, ST_OK, 11'd0},
        '{OP_IN,    32'd0,         10'd0,    32'h0000_0005, 0, ST_OK, 11'd0},
        '{OP_ADD,   32'd0,         10'd0,    32'd0,         0, ST_OK, 11'd0},
        '{OP_BRF,   32'd0,         10'd30,   32'd0,         0, ST_OK, 11'd0},
        '{OP_BR,    32'd0,         10'd31,   32'd0,         0, ST_OK, 11'd0},
        '{OP_LOADI, 32'hdead_beef, 10'd0,    32'd0,         0, ST_OK, 11'd0},
        '{OP_OUT,   32'd0,         10'd0,    32'd0,         0, ST_OK, 11'd0}
    };

    initial
    begin
        exec_result_t t;
        int           cause;
        int           burst;
        stack_ptr = 0;
        prog_ctr = 0;
        prog_len = 0;
        is_halted = 0;
        mismatches = 0;
        stall_left = 0;
        dog_count = 0;
        idle_on = 1;
        for (int i = 0; i < 1024; i++)
        begin
            opnd_stack[i] = '0;
            data_mem[i] = '0;
        end
        cause = $urandom_range(0, 5);
        // filling the stack to overflow takes one push per entry, so less random traffic then
        burst = (cause == 5) ? 100 : 500;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        write_length(11'd0);
        // above the program size, clamps to the full program
        write_length(11'd2047);

        foreach (directed[i])
        begin
            t = '0;
            t.status = directed[i].st;
            t.next_pc = directed[i].npc;
            send_instr(directed[i].op, directed[i].imm, directed[i].addr, directed[i].inv,
                       directed[i].known, t);
        end

        repeat (burst) send_legal();
        write_length(11'($urandom_range(prog_ctr + 1, PROG_MAX)));
        repeat (burst) send_legal();
        write_length(11'($urandom_range(prog_ctr + 1, 2047)));
        repeat (burst * 3 / 5) send_legal();
        write_length(11'd1024);
        repeat (burst / 5) send_legal();

        // last part: no idling, then one way of halting
        drain();
        idle_on = 0;
        case (cause)
            0: send_instr(5'($urandom_range(22, 31)), $urandom, 10'($urandom), $urandom);
            1:
            begin
                while (stack_ptr > 0)
                    send_guarded(OP_POP, $urandom);
                send_guarded(($urandom_range(0, 1) == 0) ? OP_OUT : OP_ADD, $urandom);
            end
            2:
            begin
                send_guarded(OP_LOADI, pick_value());
                send_guarded(OP_LOADI, 32'd0);
                send_guarded(OP_DIV, 32'd0);
            end
            3: send_guarded(OP_STOP, 32'd0);
            4:
            begin
                write_length(11'(prog_ctr + 1));
                send_instr(OP_IN, $urandom, 10'($urandom), pick_value());
            end
            default:
            begin
                while (stack_ptr < STACK_WORDS)
                    send_guarded(OP_LOADI, $urandom);
                send_guarded(OP_IN, 32'd0);
            end
        endcase
        repeat (6) send_instr(5'($urandom), $urandom, 10'($urandom), $urandom);
        drain();
        repeat (60) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("stack_machine_execute_tb: PASS");
        else
            $display("stack_machine_execute_tb: FAIL");
        $finish;
    end
endmodule
